// ----- rtl/v3a_pkg.sv -----
`timescale 1ns / 1ps
package v3a_pkg;

    localparam int W          = 32;            // data word width
    localparam int FRAC       = 16;            // fraction bits
    localparam int PW         = 2 * W;         // exact product width
    localparam int SUMW       = PW + 3;        // sum of three products, with headroom
    localparam int SQ_STAGES  = W;             // one root bit per stage
    localparam int QW         = FRAC + 1;      // normalize quotient never exceeds 2^FRAC
    localparam int DIV_STAGES = QW;            // one quotient bit per stage
    localparam int NUMW       = W + FRAC;      // normalize dividend width

    typedef logic signed [W-1:0] word_t;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_DOT   = 3'd3,
        OP_CROSS = 3'd4,
        OP_LEN   = 3'd5,
        OP_NORM  = 3'd6
    } op_t;

    typedef struct packed {
        logic [W-1:0] v;
        logic         ovf;
    } sat_t;

    // clamp a wide signed value to the W-bit range
    function automatic sat_t sat(input logic signed [SUMW-1:0] x);
        logic signed [SUMW-1:0] maxv;
        logic signed [SUMW-1:0] minv;
        sat_t r;
        maxv = $signed({{(SUMW-W+1){1'b0}}, {(W-1){1'b1}}});
        minv = -maxv - SUMW'(1);
        if (x > maxv) begin
            r.v   = {1'b0, {(W-1){1'b1}}};
            r.ovf = 1'b1;
        end else if (x < minv) begin
            r.v   = {1'b1, {(W-1){1'b0}}};
            r.ovf = 1'b1;
        end else begin
            r.v   = x[W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/v3a_isqrt.sv -----
`timescale 1ns / 1ps
module v3a_isqrt (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [v3a_pkg::PW-1:0]  n,
    output logic [v3a_pkg::W-1:0]   root
);
    import v3a_pkg::*;

    logic [PW-1:0] n_reg    [SQ_STAGES];
    logic [W:0]    rem_reg  [SQ_STAGES];
    logic [W-1:0]  root_reg [SQ_STAGES];

    // digit-by-digit root, two radicand bits per stage
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
        logic [PW-1:0] n_in;
        logic [W:0]    r_in;
        logic [W-1:0]  q_in;
        logic [W+2:0]  trial;
        logic [W+2:0]  test;
        logic          ge;
        if (k == 0) begin : g_first
            assign n_in = n;
            assign r_in = '0;
            assign q_in = '0;
        end else begin : g_rest
            assign n_in = n_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign q_in = root_reg[k-1];
        end
        assign trial = {r_in, n_in[PW-1:PW-2]};
        assign test  = {1'b0, q_in, 2'b01};
        assign ge    = trial >= test;
        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]    <= {n_in[PW-3:0], 2'b00};
                rem_reg[k]  <= ge ? (W+1)'(trial - test) : trial[W:0];
                root_reg[k] <= {q_in[W-2:0], ge};
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

// ----- rtl/v3a_div.sv -----
`timescale 1ns / 1ps
module v3a_div (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [v3a_pkg::W-1:0]   num,   // magnitude, scaled up by 2^FRAC inside
    input  logic [v3a_pkg::W-1:0]   den,
    output logic [v3a_pkg::QW-1:0]  quo
);
    import v3a_pkg::*;

    logic [NUMW-1:0] r_reg [DIV_STAGES];
    logic [W-1:0]    d_reg [DIV_STAGES];
    logic [QW-1:0]   q_reg [DIV_STAGES];

    // restoring division, quotient MSB first; num <= den so QW bits suffice
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
        logic [NUMW-1:0] r_in;
        logic [W-1:0]    d_in;
        logic [QW-1:0]   q_in;
        logic [NUMW:0]   ds;
        logic            ge;
        if (k == 0) begin : g_first
            assign r_in = {num, {FRAC{1'b0}}};
            assign d_in = den;
            assign q_in = '0;
        end else begin : g_rest
            assign r_in = r_reg[k-1];
            assign d_in = d_reg[k-1];
            assign q_in = q_reg[k-1];
        end
        assign ds = {{(NUMW+1-W){1'b0}}, d_in} << (QW - 1 - k);
        assign ge = {1'b0, r_in} >= ds;
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k] <= ge ? NUMW'({1'b0, r_in} - ds) : r_in;
                d_reg[k] <= d_in;
                q_reg[k] <= {q_in[QW-2:0], ge};
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];

endmodule

// ----- rtl/vec3_alu.sv -----
`timescale 1ns / 1ps
// Channel | Dir | tdata (LSB up)                                  | tuser
// s_      | in  | a_x, a_y, a_z, b_x, b_y, b_z, scale_factor      | opcode[2:0]
// m_      | out | res_x, res_y, res_z, res_scalar                 | overflow
//
// Fully pipelined: one item per cycle while m_ is not stalled, along the same path for every
// opcode (operand mux, multiply, sum/saturate, 32 root stages, 17 quotient stages, output
// register).
// The root and quotient chains set the depth: one bit per stage.
// Reset (aresetn low, synchronous) clears all valid bits; data regs are not reset.
// A stall on m_ freezes the whole pipe; s_tready follows the output stage.
module vec3_alu (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
    input  logic [2:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // res_x, res_y, res_z, res_scalar
    output logic [0:0]   m_tuser    // overflow
);
    import v3a_pkg::*;

    // item context carried alongside the root/quotient chains
    typedef struct packed {
        op_t          op;
        word_t        ax, ay, az;
        logic [W-1:0] rx, ry, rz, rs;
        logic         ovf;
    } sb_t;

    logic adv;   // pipe advance
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: operand select ----------------
    word_t in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_s;
    op_t   in_op;
    assign in_ax = s_tdata[0*W +: W];
    assign in_ay = s_tdata[1*W +: W];
    assign in_az = s_tdata[2*W +: W];
    assign in_bx = s_tdata[3*W +: W];
    assign in_by = s_tdata[4*W +: W];
    assign in_bz = s_tdata[5*W +: W];
    assign in_s  = s_tdata[6*W +: W];
    assign in_op = op_t'(s_tuser);

    word_t ma_next [6];
    word_t mb_next [6];
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            ma_next[i] = '0;
            mb_next[i] = '0;
        end
        unique case (in_op)
            OP_SCALE: begin
                ma_next[0] = in_ax; mb_next[0] = in_s;
                ma_next[1] = in_ay; mb_next[1] = in_s;
                ma_next[2] = in_az; mb_next[2] = in_s;
            end
            OP_DOT: begin
                ma_next[0] = in_ax; mb_next[0] = in_bx;
                ma_next[1] = in_ay; mb_next[1] = in_by;
                ma_next[2] = in_az; mb_next[2] = in_bz;
            end
            OP_CROSS: begin
                ma_next[0] = in_ay; mb_next[0] = in_bz;
                ma_next[1] = in_az; mb_next[1] = in_by;
                ma_next[2] = in_az; mb_next[2] = in_bx;
                ma_next[3] = in_ax; mb_next[3] = in_bz;
                ma_next[4] = in_ax; mb_next[4] = in_by;
                ma_next[5] = in_ay; mb_next[5] = in_bx;
            end
            OP_LEN, OP_NORM: begin
                ma_next[0] = in_ax; mb_next[0] = in_ax;
                ma_next[1] = in_ay; mb_next[1] = in_ay;
                ma_next[2] = in_az; mb_next[2] = in_az;
            end
            default: ;
        endcase
    end

    logic  v1_reg, v2_reg, v3_reg;
    op_t   op1_reg, op2_reg;
    word_t a1_reg [3];
    word_t b1_reg [3];
    word_t a2_reg [3];
    word_t b2_reg [3];
    word_t ma_reg [6];
    word_t mb_reg [6];
    logic signed [PW-1:0] p_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg <= in_op;
            a1_reg  <= '{in_ax, in_ay, in_az};
            b1_reg  <= '{in_bx, in_by, in_bz};
            ma_reg  <= ma_next;
            mb_reg  <= mb_next;
            // stage 2: products
            op2_reg <= op1_reg;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            for (int i = 0; i < 6; i++) begin
                p_reg[i] <= ma_reg[i] * mb_reg[i];
            end
        end
    end

    // ---------------- stage 3: sums, shift, saturate ----------------
    sb_t           sb3_next;
    logic [PW-1:0] sq_next;
    sat_t          sx, sy, sz, ss;

    always_comb begin
        sx = '0;
        sy = '0;
        sz = '0;
        ss = '0;
        unique case (op2_reg)
            OP_ADD: begin
                sx = sat(SUMW'(a2_reg[0]) + SUMW'(b2_reg[0]));
                sy = sat(SUMW'(a2_reg[1]) + SUMW'(b2_reg[1]));
                sz = sat(SUMW'(a2_reg[2]) + SUMW'(b2_reg[2]));
            end
            OP_SUB: begin
                sx = sat(SUMW'(a2_reg[0]) - SUMW'(b2_reg[0]));
                sy = sat(SUMW'(a2_reg[1]) - SUMW'(b2_reg[1]));
                sz = sat(SUMW'(a2_reg[2]) - SUMW'(b2_reg[2]));
            end
            OP_SCALE: begin
                sx = sat(SUMW'(p_reg[0]) >>> FRAC);
                sy = sat(SUMW'(p_reg[1]) >>> FRAC);
                sz = sat(SUMW'(p_reg[2]) >>> FRAC);
            end
            OP_DOT: begin
                ss = sat((SUMW'(p_reg[0]) + SUMW'(p_reg[1]) + SUMW'(p_reg[2])) >>> FRAC);
            end
            OP_CROSS: begin
                sx = sat((SUMW'(p_reg[0]) - SUMW'(p_reg[1])) >>> FRAC);
                sy = sat((SUMW'(p_reg[2]) - SUMW'(p_reg[3])) >>> FRAC);
                sz = sat((SUMW'(p_reg[4]) - SUMW'(p_reg[5])) >>> FRAC);
            end
            default: ;
        endcase
        // squares are non-negative and their sum fits PW bits
        sq_next      = $unsigned(p_reg[0]) + $unsigned(p_reg[1]) + $unsigned(p_reg[2]);
        sb3_next.op  = op2_reg;
        sb3_next.ax  = a2_reg[0];
        sb3_next.ay  = a2_reg[1];
        sb3_next.az  = a2_reg[2];
        sb3_next.rx  = sx.v;
        sb3_next.ry  = sy.v;
        sb3_next.rz  = sz.v;
        sb3_next.rs  = ss.v;
        sb3_next.ovf = sx.ovf | sy.ovf | sz.ovf | ss.ovf;
    end

    sb_t           sb3_reg;
    logic [PW-1:0] sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sb3_reg <= sb3_next;
            sq_reg  <= sq_next;
        end
    end

    // ---------------- root chain ----------------
    logic [W-1:0] len;
    v3a_isqrt u_isqrt (
        .aclk (aclk),
        .en   (adv),
        .n    (sq_reg),
        .root (len)
    );

    sb_t  sq_sb_reg [SQ_STAGES];
    logic sq_v_reg  [SQ_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQ_STAGES; i++) sq_v_reg[i] <= 1'b0;
        end else if (adv) begin
            sq_v_reg[0] <= v3_reg;
            for (int i = 1; i < SQ_STAGES; i++) sq_v_reg[i] <= sq_v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_sb_reg[0] <= sb3_reg;
            for (int i = 1; i < SQ_STAGES; i++) sq_sb_reg[i] <= sq_sb_reg[i-1];
        end
    end

    // ---------------- quotient chain (normalize) ----------------
    sb_t          sb_r;
    logic [W-1:0] mag_x, mag_y, mag_z;
    logic [QW-1:0] qx, qy, qz;
    assign sb_r  = sq_sb_reg[SQ_STAGES-1];
    assign mag_x = sb_r.ax[W-1] ? W'(-sb_r.ax) : sb_r.ax;
    assign mag_y = sb_r.ay[W-1] ? W'(-sb_r.ay) : sb_r.ay;
    assign mag_z = sb_r.az[W-1] ? W'(-sb_r.az) : sb_r.az;

    v3a_div u_div_x (.aclk(aclk), .en(adv), .num(mag_x), .den(len), .quo(qx));
    v3a_div u_div_y (.aclk(aclk), .en(adv), .num(mag_y), .den(len), .quo(qy));
    v3a_div u_div_z (.aclk(aclk), .en(adv), .num(mag_z), .den(len), .quo(qz));

    sb_t          dv_sb_reg  [DIV_STAGES];
    logic [W-1:0] dv_len_reg [DIV_STAGES];
    logic         dv_v_reg   [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_STAGES; i++) dv_v_reg[i] <= 1'b0;
        end else if (adv) begin
            dv_v_reg[0] <= sq_v_reg[SQ_STAGES-1];
            for (int i = 1; i < DIV_STAGES; i++) dv_v_reg[i] <= dv_v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_sb_reg[0]  <= sb_r;
            dv_len_reg[0] <= len;
            for (int i = 1; i < DIV_STAGES; i++) begin
                dv_sb_reg[i]  <= dv_sb_reg[i-1];
                dv_len_reg[i] <= dv_len_reg[i-1];
            end
        end
    end

    // ---------------- output stage ----------------
    sb_t          sb_o;
    logic [W-1:0] len_o;
    sat_t         sl;
    logic [W-1:0] rx_next, ry_next, rz_next, rs_next;
    logic         ovf_next;
    assign sb_o  = dv_sb_reg[DIV_STAGES-1];
    assign len_o = dv_len_reg[DIV_STAGES-1];
    assign sl    = sat($signed({{(SUMW-W){1'b0}}, len_o}));

    always_comb begin
        rx_next  = sb_o.rx;
        ry_next  = sb_o.ry;
        rz_next  = sb_o.rz;
        rs_next  = sb_o.rs;
        ovf_next = sb_o.ovf;
        unique case (sb_o.op)
            OP_LEN: begin
                rs_next  = sl.v;
                ovf_next = sl.ovf;
            end
            OP_NORM: begin
                // zero length only for a zero vector: pass it through
                if (len_o == '0) begin
                    rx_next = sb_o.ax;
                    ry_next = sb_o.ay;
                    rz_next = sb_o.az;
                end else begin
                    rx_next = sb_o.ax[W-1] ? -W'(qx) : W'(qx);
                    ry_next = sb_o.ay[W-1] ? -W'(qy) : W'(qy);
                    rz_next = sb_o.az[W-1] ? -W'(qz) : W'(qz);
                end
                ovf_next = 1'b0;
            end
            default: ;
        endcase
    end

    logic         m_tvalid_reg;
    logic [W-1:0] rx_reg, ry_reg, rz_reg, rs_reg;
    logic         ovf_reg;
    op_t          op_o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv_v_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            rz_reg   <= rz_next;
            rs_reg   <= rs_next;
            ovf_reg  <= ovf_next;
            op_o_reg <= sb_o.op;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {rs_reg, rz_reg, ry_reg, rx_reg};
    assign m_tuser[0] = ovf_reg;

    // ---------------- checks ----------------
    // normalized components stay within +-1.0
    a_norm_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && op_o_reg == OP_NORM) |-> !ovf_reg)
        else $error("normalize result flagged overflow");

    // scalar-only ops leave the vector fields clear
    a_scalar_vec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (op_o_reg == OP_DOT || op_o_reg == OP_LEN))
            |-> (rx_reg == '0 && ry_reg == '0 && rz_reg == '0))
        else $error("vector field set on scalar op");

    // the only stall source is the output side
    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid_reg && !m_tready))
        else $error("input stalled without output backpressure");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid_reg)
        else $error("output valid after reset");

endmodule

// ----- dv/vec3_alu_test.sv -----
`timescale 1ns / 1ps
module vec3_alu_test;
    import v3a_pkg::*;

    localparam int PIPE_DEPTH = 53;
    localparam int STALL_LIMIT = 4000;
    localparam int N_RANDOM = 1130;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] scalar;
        logic        ovf;
    } alu_result_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] ax, ay, az, bx, by, bz, sf;
        bit          has_fixed;   // row carries a typed-in expected result
        alu_result_t fixed;
    } alu_vec_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;

    alu_result_t pending_results[$];
    alu_vec_t    vec_table[$];
    int          n_fail = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;   // no idling in the closing stretch

    always #5 aclk = ~aclk;

    vec3_alu u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // clamp to 32-bit signed, noting any saturation
    function automatic logic [31:0] clamp32(input longint v, inout bit ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // floor(s / 2^16) of a 128-bit sum, limited to +-2^62; >>> on signed floors
    function automatic longint fix_sum(input logic signed [127:0] s);
        logic signed [127:0] q;
        q = s >>> 16;
        if (q > 128'sd4611686018427387904) return 64'sd4611686018427387904;
        if (q < -128'sd4611686018427387904) return -64'sd4611686018427387904;
        return longint'(q);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        r = '0;
        for (int b = 31; b >= 0; b--)
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n && (r | (64'd1 << b)) < 64'd4294967296)
                r = r | (64'd1 << b);
        return r;
    endfunction

    function automatic alu_result_t vec_alu_predict(input alu_vec_t v);
        alu_result_t r;
        bit o;
        longint ax, ay, az, bx, by, bz, s, len;
        logic signed [127:0] p0, p1, p2;
        logic [63:0] sq;
        ax = longint'($signed(v.ax)); ay = longint'($signed(v.ay)); az = longint'($signed(v.az));
        bx = longint'($signed(v.bx)); by = longint'($signed(v.by)); bz = longint'($signed(v.bz));
        s  = longint'($signed(v.sf));
        r = '0;
        o = 1'b0;
        case (op_t'(v.op))
            OP_ADD: begin
                r.x = clamp32(ax + bx, o); r.y = clamp32(ay + by, o); r.z = clamp32(az + bz, o);
            end
            OP_SUB: begin
                r.x = clamp32(ax - bx, o); r.y = clamp32(ay - by, o); r.z = clamp32(az - bz, o);
            end
            OP_SCALE: begin
                r.x = clamp32(fix_sum(ax * s), o);
                r.y = clamp32(fix_sum(ay * s), o);
                r.z = clamp32(fix_sum(az * s), o);
            end
            OP_DOT: begin
                p0 = ax * bx; p1 = ay * by; p2 = az * bz;
                r.scalar = clamp32(fix_sum(p0 + p1 + p2), o);
            end
            OP_CROSS: begin
                p0 = ay * bz; p1 = az * by;
                r.x = clamp32(fix_sum(p0 - p1), o);
                p0 = az * bx; p1 = ax * bz;
                r.y = clamp32(fix_sum(p0 - p1), o);
                p0 = ax * by; p1 = ay * bx;
                r.z = clamp32(fix_sum(p0 - p1), o);
            end
            OP_LEN, OP_NORM: begin
                // each square <= 2^62, sum < 2^64 so unsigned 64 bits is exact
                sq = 64'(ax * ax) + 64'(ay * ay) + 64'(az * az);
                len = longint'(int_sqrt(sq));
                if (op_t'(v.op) == OP_LEN) begin
                    r.scalar = clamp32(len, o);
                end else if (len == 0) begin
                    r.x = v.ax; r.y = v.ay; r.z = v.az;
                end else begin
                    // SV division truncates toward zero
                    r.x = clamp32((ax * 65536) / len, o);
                    r.y = clamp32((ay * 65536) / len, o);
                    r.z = clamp32((az * 65536) / len, o);
                end
            end
            default: ;
        endcase
        r.ovf = o;
        return r;
    endfunction

    function automatic alu_vec_t mk_row(input logic [2:0] op,
            input logic [31:0] ax, ay, az, bx, by, bz, sf);
        alu_vec_t v;
        v = '{op, ax, ay, az, bx, by, bz, sf, 1'b0, '0};
        return v;
    endfunction

    function automatic alu_vec_t mk_fixed(input alu_vec_t v, input alu_result_t r);
        v.has_fixed = 1'b1;
        v.fixed = r;
        return v;
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 65535) << $urandom_range(0, 16);
            3: return -($urandom_range(0, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    // directed rows: extremes, every opcode, zero-length normalize, opcode 7; then N_RANDOM random rows
    task automatic build_table();
        logic [31:0] mx, mn, one;
        mx = 32'h7fffffff; mn = 32'h80000000; one = 32'h00010000;
        vec_table.push_back(mk_fixed(mk_row(OP_ADD, 0, 0, 0, 0, 0, 0, 0), '0));
        vec_table.push_back(mk_fixed(mk_row(OP_ADD, mx, mn, 1, 1, mn, 2, 0),
                                     '{mx, mn, 32'd3, 32'd0, 1'b1}));
        vec_table.push_back(mk_fixed(mk_row(OP_SUB, mn, mx, 5, 1, mn, 2, 0),
                                     '{mn, mx, 32'd3, 32'd0, 1'b1}));
        vec_table.push_back(mk_fixed(mk_row(OP_SCALE, one, mn, mx, 0, 0, 0, one),
                                     '{one, mn, mx, 32'd0, 1'b0}));
        vec_table.push_back(mk_row(OP_SCALE, mx, mn, mx, 0, 0, 0, mx));
        vec_table.push_back(mk_row(OP_SCALE, mn, mn, 32'hffffffff, 0, 0, 0, mn));
        vec_table.push_back(mk_fixed(mk_row(OP_DOT, mx, mx, mx, mx, mx, mx, 0),
                                     '{32'd0, 32'd0, 32'd0, mx, 1'b1}));
        vec_table.push_back(mk_fixed(mk_row(OP_DOT, mx, mn, mx, mn, mx, mn, 0),
                                     '{32'd0, 32'd0, 32'd0, mn, 1'b1}));
        vec_table.push_back(mk_row(OP_DOT, one, 32'hffffffff, 3, one, 1, 7, mx));
        vec_table.push_back(mk_fixed(mk_row(OP_CROSS, one, 0, 0, 0, one, 0, 0),
                                     '{32'd0, 32'd0, one, 32'd0, 1'b0}));
        vec_table.push_back(mk_row(OP_CROSS, mn, mx, mn, mx, mn, mx, 0));
        vec_table.push_back(mk_row(OP_CROSS, 32'hffffffff, 1, mn, 3, mx, 32'hfffffffe, 0));
        vec_table.push_back(mk_fixed(mk_row(OP_LEN, 3, 4, 0, mx, mx, mx, mx),
                                     '{32'd0, 32'd0, 32'd0, 32'd5, 1'b0}));
        vec_table.push_back(mk_row(OP_LEN, mn, mn, mn, 0, 0, 0, 0));
        vec_table.push_back(mk_row(OP_LEN, mx, mn, 1, 0, 0, 0, 0));
        vec_table.push_back(mk_fixed(mk_row(OP_NORM, 0, 0, 0, 5, 5, 5, 5), '0));
        vec_table.push_back(mk_fixed(mk_row(OP_NORM, 3, 0, 0, 0, 0, 0, 0),
                                     '{one, 32'd0, 32'd0, 32'd0, 1'b0}));
        vec_table.push_back(mk_row(OP_NORM, mn, mx, 1, 0, 0, 0, 0));
        vec_table.push_back(mk_row(OP_NORM, 1, 32'hffffffff, 0, 0, 0, 0, 0));
        vec_table.push_back(mk_row(OP_NORM, mn, 0, 0, 0, 0, 0, 0));
        vec_table.push_back(mk_fixed(mk_row(3'd7, mx, mx, mx, mx, mx, mx, mx), '0));
        for (int i = 0; i < N_RANDOM; i++)
            vec_table.push_back(mk_row(3'($urandom_range(0, 7)), rnd_word(), rnd_word(),
                rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word()));
    endtask

    // result side: random stall bursts, compare against oldest expectation
    initial begin
        int hold;
        alu_result_t exp_r, got;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tuser[0]};
                if (pending_results.size() == 0) begin
                    $error("result with no expectation waiting");
                    n_fail++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got.x !== exp_r.x) begin
                        $error("res_x exp %h got %h", exp_r.x, got.x); n_fail++;
                    end
                    if (got.y !== exp_r.y) begin
                        $error("res_y exp %h got %h", exp_r.y, got.y); n_fail++;
                    end
                    if (got.z !== exp_r.z) begin
                        $error("res_z exp %h got %h", exp_r.z, got.z); n_fail++;
                    end
                    if (got.scalar !== exp_r.scalar) begin
                        $error("res_scalar exp %h got %h", exp_r.scalar, got.scalar); n_fail++;
                    end
                    if (got.ovf !== exp_r.ovf) begin
                        $error("overflow exp %b got %b", exp_r.ovf, got.ovf); n_fail++;
                    end
                end
            end
            if (!aresetn || quiet) begin
                m_tready <= aresetn;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
                hold = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // input side
    initial begin
        alu_vec_t cur;
        int idx, gap, n_total;
        build_table();
        n_total = vec_table.size();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idx = 0;
        while (idx < n_total) begin
            if (idx > n_total - 100) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 11) == 0) begin
                gap = $urandom_range(1, 16);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            cur = vec_table[idx];
            s_tvalid <= 1'b1;
            s_tuser  <= cur.op;
            s_tdata  <= {cur.sf, cur.bz, cur.by, cur.bx, cur.az, cur.ay, cur.ax};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            pending_results.push_back(cur.has_fixed ? cur.fixed : vec_alu_predict(cur));
            if (cur.has_fixed && cur.fixed !== vec_alu_predict(cur)) begin
                $error("table row %0d disagrees with predictor", idx);
                n_fail++;
            end
            idx++;
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 10) @(posedge aclk);
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/v3a_pkg.sv
rtl/v3a_isqrt.sv
rtl/v3a_div.sv
rtl/vec3_alu.sv
dv/vec3_alu_test.sv
